[design/tps_pkg.sv]
// shared widths, constants and the side-band record for the triangle plane setup pipeline
package tps_pkg;

  localparam int IN_W        = 16;   // coordinate field width
  localparam int NUM_COORDS  = 9;
  localparam int DIFF_W      = 17;   // edge vector component
  localparam int PROD_W      = 34;   // edge product
  localparam int CROSS_W     = 35;   // cross product component
  localparam int MAG_W       = 34;   // cross product magnitude
  localparam int HALF_W      = 17;   // half of a magnitude for the split square
  localparam int HH_W        = 34;   // partial product of two halves
  localparam int SQ_W        = 68;   // square of a component, and the sum of squares
  localparam int Y_W         = 17;   // vertical extent fields
  localparam int Y_MARGIN    = 5;
  localparam int NORM_W      = 16;
  localparam int OFF_W       = 31;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 120;

  localparam longint OFF_MAX = 64'sd1073741823;
  localparam longint OFF_MIN = -64'sd1073741824;

  // travels with every item from input to output
  typedef struct packed {
    logic                   vld;
    logic                   degen;
    logic signed [IN_W-1:0] x1;
    logic signed [IN_W-1:0] y1;
    logic signed [IN_W-1:0] z1;
    logic signed [Y_W-1:0]  lo_y;
    logic signed [Y_W-1:0]  hi_y;
  } tps_side_t;

endpackage

[design/tps_front.sv]
// front pipeline: edges, cross product, sum of squares and the start values of the bit cells
module tps_front #(
  parameter int CB = 16,
  parameter int F  = 14,
  localparam int EW = tps_pkg::SQ_W + 2*F + 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_vld,
  input  logic [tps_pkg::IN_TDATA_W-1:0]        in_data,
  output tps_pkg::tps_side_t                    side_o,
  output logic [tps_pkg::SQ_W-1:0]              s_o,
  output logic [2:0][EW-1:0]                    e_o,
  output logic [2:0]                            sgn_o
);

  logic signed [tps_pkg::IN_W-1:0] v [tps_pkg::NUM_COORDS];
  logic signed [tps_pkg::IN_W-1:0] ymin, ymax;

  always_comb begin
    logic [tps_pkg::IN_W-1:0] raw;
    for (int i = 0; i < tps_pkg::NUM_COORDS; i++) begin
      raw  = in_data[i*tps_pkg::IN_W +: tps_pkg::IN_W];
      v[i] = tps_pkg::IN_W'(signed'(raw[CB-1:0]));
    end
    ymin = v[1];
    if (v[4] < ymin) ymin = v[4];
    if (v[7] < ymin) ymin = v[7];
    ymax = v[1];
    if (v[4] > ymax) ymax = v[4];
    if (v[7] > ymax) ymax = v[7];
  end

  // stage 1: edge vectors
  tps_pkg::tps_side_t side1_r, side1_nxt;
  logic signed [tps_pkg::DIFF_W-1:0] d1_r [3];
  logic signed [tps_pkg::DIFF_W-1:0] d2_r [3];

  always_comb begin
    side1_nxt.vld   = in_vld;
    side1_nxt.degen = 1'b0;
    side1_nxt.x1    = v[0];
    side1_nxt.y1    = v[1];
    side1_nxt.z1    = v[2];
    side1_nxt.lo_y  = tps_pkg::Y_W'(ymin) - tps_pkg::Y_W'(tps_pkg::Y_MARGIN);
    side1_nxt.hi_y  = tps_pkg::Y_W'(ymax) + tps_pkg::Y_W'(tps_pkg::Y_MARGIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.vld <= 1'b0;
    end else if (adv) begin
      side1_r <= side1_nxt;
      for (int j = 0; j < 3; j++) begin
        d1_r[j] <= tps_pkg::DIFF_W'(v[3+j]) - tps_pkg::DIFF_W'(v[j]);
        d2_r[j] <= tps_pkg::DIFF_W'(v[6+j]) - tps_pkg::DIFF_W'(v[3+j]);
      end
    end
  end

  // stage 2: edge products
  tps_pkg::tps_side_t side2_r;
  logic signed [tps_pkg::PROD_W-1:0] pa_r [3];
  logic signed [tps_pkg::PROD_W-1:0] pb_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r.vld <= 1'b0;
    end else if (adv) begin
      side2_r  <= side1_r;
      pa_r[0]  <= d1_r[1] * d2_r[2];
      pb_r[0]  <= d1_r[2] * d2_r[1];
      pa_r[1]  <= d1_r[2] * d2_r[0];
      pb_r[1]  <= d1_r[0] * d2_r[2];
      pa_r[2]  <= d1_r[0] * d2_r[1];
      pb_r[2]  <= d1_r[1] * d2_r[0];
    end
  end

  // stage 3: cross product as sign and magnitude
  tps_pkg::tps_side_t side3_r;
  logic [tps_pkg::MAG_W-1:0] mag_r [3];
  logic [2:0]                sgn3_r;

  always_ff @(posedge clk) begin
    logic signed [tps_pkg::CROSS_W-1:0] n;
    if (!rst_n) begin
      side3_r.vld <= 1'b0;
    end else if (adv) begin
      side3_r <= side2_r;
      for (int j = 0; j < 3; j++) begin
        n         = tps_pkg::CROSS_W'(pa_r[j]) - tps_pkg::CROSS_W'(pb_r[j]);
        sgn3_r[j] <= n[tps_pkg::CROSS_W-1];
        mag_r[j]  <= tps_pkg::MAG_W'(n[tps_pkg::CROSS_W-1] ? -n : n);
      end
    end
  end

  // stage 4: split squares, three half-width products per component
  tps_pkg::tps_side_t side4_r;
  logic [tps_pkg::HH_W-1:0] hh_r [3];
  logic [tps_pkg::HH_W-1:0] hl_r [3];
  logic [tps_pkg::HH_W-1:0] ll_r [3];
  logic [2:0]               sgn4_r;

  always_ff @(posedge clk) begin
    logic [tps_pkg::HALF_W-1:0] mh, ml;
    if (!rst_n) begin
      side4_r.vld <= 1'b0;
    end else if (adv) begin
      side4_r <= side3_r;
      sgn4_r  <= sgn3_r;
      for (int j = 0; j < 3; j++) begin
        mh       = mag_r[j][tps_pkg::MAG_W-1 -: tps_pkg::HALF_W];
        ml       = mag_r[j][tps_pkg::HALF_W-1:0];
        hh_r[j] <= mh * mh;
        hl_r[j] <= mh * ml;
        ll_r[j] <= ml * ml;
      end
    end
  end

  // stage 5: full squares
  tps_pkg::tps_side_t side5_r;
  logic [tps_pkg::SQ_W-1:0] sq_r [3];
  logic [2:0]               sgn5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side5_r.vld <= 1'b0;
    end else if (adv) begin
      side5_r <= side4_r;
      sgn5_r  <= sgn4_r;
      for (int j = 0; j < 3; j++) begin
        sq_r[j] <= (tps_pkg::SQ_W'(hh_r[j]) << (2*tps_pkg::HALF_W))
                 + (tps_pkg::SQ_W'(hl_r[j]) << (tps_pkg::HALF_W + 1))
                 + tps_pkg::SQ_W'(ll_r[j]);
      end
    end
  end

  // stage 6: sum of squares and the scaled targets the cells compare against
  tps_pkg::tps_side_t side6_r;

  always_ff @(posedge clk) begin
    tps_pkg::tps_side_t sd;
    if (!rst_n) begin
      side6_r.vld <= 1'b0;
    end else if (adv) begin
      sd        = side5_r;
      sd.degen  = ((sq_r[0] | sq_r[1] | sq_r[2]) == '0);
      side6_r  <= sd;
      s_o      <= sq_r[0] + sq_r[1] + sq_r[2];
      sgn_o    <= sgn5_r;
      for (int j = 0; j < 3; j++) begin
        e_o[j] <= EW'(sq_r[j]) << (2*F + 2);
      end
    end
  end

  assign side_o = side6_r;

endmodule

[design/tps_cell.sv]
// one result bit of all three normal components, restoring compare against the sum of squares
module tps_cell #(
  parameter int F = 14,
  parameter int K = 0,
  localparam int EW = tps_pkg::SQ_W + 2*F + 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  tps_pkg::tps_side_t        side_i,
  input  logic [tps_pkg::SQ_W-1:0]  s_i,
  input  logic [2:0][EW-1:0]        e_i,
  input  logic [2:0][EW-1:0]        acc_i,
  input  logic [2:0][F:0]           q_i,
  input  logic [2:0]                sgn_i,
  output tps_pkg::tps_side_t        side_o,
  output logic [tps_pkg::SQ_W-1:0]  s_o,
  output logic [2:0][EW-1:0]        e_o,
  output logic [2:0][EW-1:0]        acc_o,
  output logic [2:0][F:0]           q_o,
  output logic [2:0]                sgn_o
);

  // e holds the target minus s*(2q)^2, acc holds 2*q*s
  tps_pkg::tps_side_t side_r;
  logic [tps_pkg::SQ_W-1:0] s_r;
  logic [2:0][EW-1:0]       e_r, e_nxt, acc_r, acc_nxt;
  logic [2:0][F:0]          q_r, q_nxt;
  logic [2:0]               sgn_r;

  always_comb begin
    logic signed [EW-1:0] sw, ev, av, t, d;
    sw = signed'(EW'(s_i));
    for (int j = 0; j < 3; j++) begin
      ev = signed'(e_i[j]);
      av = signed'(acc_i[j]);
      // s*((2q+m)^2 - (2q)^2) with m = 2^(K+1)-1
      t  = (av <<< (K+2)) - (av <<< 1) + (sw <<< (2*K+2)) - (sw <<< (K+2)) + sw;
      d  = ev - t;
      if (!d[EW-1]) begin
        e_nxt[j]   = EW'(ev - (av <<< (K+2)) - (sw <<< (2*K+2)));
        acc_nxt[j] = EW'(av + (sw <<< (K+1)));
        q_nxt[j]   = q_i[j] | ((F+1)'(1) << K);
      end else begin
        e_nxt[j]   = e_i[j];
        acc_nxt[j] = acc_i[j];
        q_nxt[j]   = q_i[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (adv) begin
      side_r <= side_i;
      s_r    <= s_i;
      e_r    <= e_nxt;
      acc_r  <= acc_nxt;
      q_r    <= q_nxt;
      sgn_r  <= sgn_i;
    end
  end

  assign side_o = side_r;
  assign s_o    = s_r;
  assign e_o    = e_r;
  assign acc_o  = acc_r;
  assign q_o    = q_r;
  assign sgn_o  = sgn_r;

endmodule

[design/tps_back.sv]
// back pipeline: signed normal, plane offset with saturation, and the output register
module tps_back #(
  parameter int F = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  tps_pkg::tps_side_t                   side_i,
  input  logic [2:0][F:0]                      q_i,
  input  logic [2:0]                           sgn_i,
  output logic                                 out_vld,
  output logic [tps_pkg::OUT_TDATA_W-1:0]      out_data,
  output logic                                 out_degen
);

  localparam int QW  = F + 2;
  localparam int PW  = QW + tps_pkg::IN_W;
  localparam int OSW = (PW + 2 > 32) ? PW + 2 : 32;
  localparam int NXW = (QW > tps_pkg::NORM_W) ? QW : tps_pkg::NORM_W;
  localparam logic signed [OSW-1:0] SAT_HI = OSW'(tps_pkg::OFF_MAX);
  localparam logic signed [OSW-1:0] SAT_LO = OSW'(tps_pkg::OFF_MIN);

  // stage 1: apply signs, products with the first vertex
  tps_pkg::tps_side_t side1_r;
  logic signed [QW-1:0] qs_r [3];
  logic signed [PW-1:0] pr_r [3];

  always_ff @(posedge clk) begin
    logic signed [QW-1:0]           qs;
    logic signed [tps_pkg::IN_W-1:0] cv;
    if (!rst_n) begin
      side1_r.vld <= 1'b0;
    end else if (adv) begin
      side1_r <= side_i;
      for (int j = 0; j < 3; j++) begin
        qs = signed'({1'b0, q_i[j]});
        if (sgn_i[j]) qs = -qs;
        case (j)
          0:       cv = side_i.x1;
          1:       cv = side_i.y1;
          default: cv = side_i.z1;
        endcase
        qs_r[j] <= qs;
        pr_r[j] <= qs * cv;
      end
    end
  end

  // stage 2: output register
  logic                             vld_r;
  logic [tps_pkg::OUT_TDATA_W-1:0]  data_r, data_nxt;
  logic                             degen_r;

  always_comb begin
    logic signed [OSW-1:0] off;
    logic signed [NXW-1:0] nx;
    logic [tps_pkg::NORM_W-1:0] nrm [3];
    off = -(OSW'(pr_r[0]) + OSW'(pr_r[1]) + OSW'(pr_r[2]));
    if (off > SAT_HI) off = SAT_HI;
    if (off < SAT_LO) off = SAT_LO;
    for (int j = 0; j < 3; j++) begin
      nx     = NXW'(qs_r[j]);
      nrm[j] = side1_r.degen ? '0 : nx[tps_pkg::NORM_W-1:0];
    end
    if (side1_r.degen) off = '0;
    data_nxt = {7'b0, side1_r.hi_y, side1_r.lo_y, off[tps_pkg::OFF_W-1:0],
                nrm[2], nrm[1], nrm[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r   <= side1_r.vld;
      data_r  <= data_nxt;
      degen_r <= side1_r.degen;
    end
  end

  assign out_vld   = vld_r;
  assign out_data  = data_r;
  assign out_degen = degen_r;

endmodule

[design/triangle_plane_setup_core.sv]
// Triangle plane setup: takes one triangle of three vertices per beat and returns its unit
// normal in Q1.NORMAL_FRAC_BITS, the plane offset -(n.a), the widened vertical extent and a
// flag for a zero cross product. A new triangle is taken in every cycle unless the output
// stalls; each result passes through 6 front stages for edges, cross product and sum of
// squares, one cell per result bit of the normal, and 2 back stages for the offset and the
// output register. When the output beat is not taken the whole pipeline holds.
module triangle_plane_setup_core #(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, 16 bits each
  input  logic [tps_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // normal_x[15:0], normal_y[31:16], normal_z[47:32], plane_offset[78:48],
  // lower_y[95:79], upper_y[112:96], zeros above
  output logic [tps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // degenerate
  output logic                               out_tuser
);

  localparam int F  = NORMAL_FRAC_BITS;
  localparam int EW = tps_pkg::SQ_W + 2*F + 6;
  localparam int NC = F + 1;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv && rst_n;

  tps_pkg::tps_side_t        side_c [NC+1];
  logic [tps_pkg::SQ_W-1:0]  s_c    [NC+1];
  logic [2:0][EW-1:0]        e_c    [NC+1];
  logic [2:0][EW-1:0]        acc_c  [NC+1];
  logic [2:0][F:0]           q_c    [NC+1];
  logic [2:0]                sgn_c  [NC+1];

  tps_front #(.CB(COORD_BITS), .F(F)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_tvalid),
    .in_data(in_tdata),
    .side_o (side_c[0]),
    .s_o    (s_c[0]),
    .e_o    (e_c[0]),
    .sgn_o  (sgn_c[0])
  );

  assign acc_c[0] = '0;
  assign q_c[0]   = '0;

  // most significant bit first
  for (genvar g = 0; g < NC; g++) begin : g_cell
    tps_cell #(.F(F), .K(F - g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .side_i(side_c[g]),
      .s_i   (s_c[g]),
      .e_i   (e_c[g]),
      .acc_i (acc_c[g]),
      .q_i   (q_c[g]),
      .sgn_i (sgn_c[g]),
      .side_o(side_c[g+1]),
      .s_o   (s_c[g+1]),
      .e_o   (e_c[g+1]),
      .acc_o (acc_c[g+1]),
      .q_o   (q_c[g+1]),
      .sgn_o (sgn_c[g+1])
    );
  end

  tps_back #(.F(F)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .side_i   (side_c[NC]),
    .q_i      (q_c[NC]),
    .sgn_i    (sgn_c[NC]),
    .out_vld  (out_tvalid),
    .out_data (out_tdata),
    .out_degen(out_tuser)
  );

  logic signed [tps_pkg::Y_W-1:0] chk_lo, chk_hi;
  assign chk_lo = out_tdata[95:79];
  assign chk_hi = out_tdata[112:96];

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[78:0] == '0)
    else $error("degenerate triangle with nonzero normal or offset");

  a_extent_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> chk_lo < chk_hi)
    else $error("lower extent not below upper extent");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[tps_pkg::OUT_TDATA_W-1:113] == '0)
    else $error("output padding bits set");

endmodule
